@@ rtl/joystick_center_calibrate_and_map_macros.svh @@
// Assertion macros for the joystick centre calibration and mapping block.
// No dependencies; included by the top level.
`ifndef JOYSTICK_CENTER_CALIBRATE_AND_MAP_MACROS_SVH
`define JOYSTICK_CENTER_CALIBRATE_AND_MAP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JCCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JCCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/jccm_pkg.sv @@
// Shared types and constants for the joystick centre calibration and mapping block.
// No dependencies.
package jccm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 6;
    localparam int PCT_W    = 8;

    // Calibration run length
    localparam int SAMPLES = 50;

    localparam logic [SAMPLE_W-1:0] DEADZONE_RESET = 12'd150;
    localparam logic [SAMPLE_W-1:0] CENTRE_RESET   = 12'd2048;

    // Average by reciprocal: exact for sums below 2**SUM_W and divisors below 2**CNT_W
    localparam int DIV_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    // Percentage scaling: mag * 100 / 2048
    localparam int SCALED_W  = SAMPLE_W + 7;
    localparam int PCT_SHIFT = 11;
    localparam logic [SCALED_W-1:0] PCT_SCALE = SCALED_W'(100);
    localparam logic [PCT_W-1:0]    PCT_MAX   = PCT_W'(100);

    localparam logic ACT_MAP = 1'b0;
    localparam logic ACT_CAL = 1'b1;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample_x;
        logic [SAMPLE_W-1:0] sample_y;
    } in_word_t;

    typedef struct packed {
        logic signed [PCT_W-1:0] percent_x;
        logic signed [PCT_W-1:0] percent_y;
        logic                    calibration_done;
    } out_word_t;

endpackage

@@ rtl/jccm_axis_map.sv @@
// One axis of the deflection mapper: centre offset, deadzone, scale and clamp.
// Depends on jccm_pkg.
module jccm_axis_map
    import jccm_pkg::*;
(
    input  logic [SAMPLE_W-1:0]    sample,
    input  logic [SAMPLE_W-1:0]    centre,
    input  logic [SAMPLE_W-1:0]    deadzone,
    output logic signed [PCT_W-1:0] percent
);

    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] mag_dz;
    logic [SCALED_W-1:0] scaled;
    logic [PCT_W-1:0]    quot;
    logic [PCT_W-1:0]    sat;

    always_comb
    begin
        neg    = sample < centre;
        mag    = neg ? (centre - sample) : (sample - centre);
        mag_dz = (mag < deadzone) ? '0 : mag;
        scaled = SCALED_W'(mag_dz) * PCT_SCALE;
        // max 199, fits in PCT_W bits
        quot   = scaled[PCT_SHIFT +: PCT_W];
        sat    = (quot > PCT_MAX) ? PCT_MAX : quot;
        percent = neg ? $signed(-sat) : $signed(sat);
    end

endmodule

@@ rtl/joystick_center_calibrate_and_map.sv @@
// Top level of the joystick centre calibration and mapping block.
// Depends on jccm_pkg, jccm_axis_map and joystick_center_calibrate_and_map_macros.svh.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  sample   | sample_valid, sample_stall, sample_word | in
//  result   | result_valid, result_stall, result_word | out
//  config   | cfg_we, cfg_data (deadzone)          | in
//
// Input register, then result register; one word a cycle while result_stall is low.
// The centre average (reciprocal multiply) sets the path.
// rst_n is asynchronous: deadzone 150, centres 2048, accumulators and count zero.
// A stall on the result side fills both registers, then stalls the sample side.
`include "joystick_center_calibrate_and_map_macros.svh"

module joystick_center_calibrate_and_map
    import jccm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  in_word_t            sample_word,
    output logic                result_valid,
    input  logic                result_stall,
    output out_word_t           result_word,
    input  logic                cfg_we,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    logic                in_valid_reg;
    in_word_t            in_word_reg;
    logic                result_valid_reg, result_valid_next;
    out_word_t           result_word_reg, result_word_next;
    logic [SAMPLE_W-1:0] deadzone_reg;
    logic [SAMPLE_W-1:0] centre_x_reg, centre_x_next;
    logic [SAMPLE_W-1:0] centre_y_reg, centre_y_next;
    logic [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                out_free;
    logic                advance;
    logic                take;
    logic [SUM_W-1:0]    sum_x_add, sum_y_add;
    logic [CNT_W-1:0]    count_add;
    logic                run_end;
    logic [PROD_W-1:0]   prod_x, prod_y;
    logic signed [PCT_W-1:0] pct_x, pct_y;

    assign out_free     = !result_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign sample_stall = in_valid_reg && !out_free;
    assign take         = sample_valid && !sample_stall;

    jccm_axis_map u_map_x (
        .sample   (in_word_reg.sample_x),
        .centre   (centre_x_reg),
        .deadzone (deadzone_reg),
        .percent  (pct_x)
    );

    jccm_axis_map u_map_y (
        .sample   (in_word_reg.sample_y),
        .centre   (centre_y_reg),
        .deadzone (deadzone_reg),
        .percent  (pct_y)
    );

    always_comb
    begin
        sum_x_add = sum_x_reg + SUM_W'(in_word_reg.sample_x);
        sum_y_add = sum_y_reg + SUM_W'(in_word_reg.sample_y);
        count_add = count_reg + CNT_W'(1);
        run_end   = count_add == CNT_W'(SAMPLES);
        prod_x    = PROD_W'(sum_x_add) * PROD_W'(DIV_RECIP);
        prod_y    = PROD_W'(sum_y_add) * PROD_W'(DIV_RECIP);

        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        count_next        = count_reg;
        centre_x_next     = centre_x_reg;
        centre_y_next     = centre_y_reg;
        result_word_next  = result_word_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (advance)
        begin
            result_valid_next = 1'b1;
            unique case (in_word_reg.action)
                ACT_CAL:
                begin
                    result_word_next.percent_x        = '0;
                    result_word_next.percent_y        = '0;
                    result_word_next.calibration_done = run_end;
                    if (run_end)
                    begin
                        centre_x_next = prod_x[DIV_SHIFT +: SAMPLE_W];
                        centre_y_next = prod_y[DIV_SHIFT +: SAMPLE_W];
                        sum_x_next    = '0;
                        sum_y_next    = '0;
                        count_next    = '0;
                    end
                    else
                    begin
                        sum_x_next = sum_x_add;
                        sum_y_next = sum_y_add;
                        count_next = count_add;
                    end
                end
                ACT_MAP:
                begin
                    result_word_next.percent_x        = pct_x;
                    result_word_next.percent_y        = pct_y;
                    result_word_next.calibration_done = 1'b0;
                end
                default:
                begin
                    result_word_next = result_word_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            deadzone_reg     <= DEADZONE_RESET;
            centre_x_reg     <= CENTRE_RESET;
            centre_y_reg     <= CENTRE_RESET;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (take || advance)
                in_valid_reg <= take;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                deadzone_reg <= cfg_data;
            centre_x_reg <= centre_x_next;
            centre_y_reg <= centre_y_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            count_reg    <= count_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            in_word_reg <= sample_word;
        result_word_reg <= result_word_next;
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    `JCCM_ASSERT_NOW(a_cal_zero_pct,
        result_valid_reg && result_word_reg.calibration_done,
        result_word_reg.percent_x == '0 && result_word_reg.percent_y == '0,
        "calibration word carries non-zero deflection")
    `JCCM_ASSERT_NOW(a_pct_range,
        result_valid_reg,
        $signed(result_word_reg.percent_x) >= -100 && $signed(result_word_reg.percent_x) <= 100
        && $signed(result_word_reg.percent_y) >= -100
        && $signed(result_word_reg.percent_y) <= 100,
        "deflection outside -100..100")
    `JCCM_ASSERT_NOW(a_count_bound, 1'b1, count_reg < CNT_W'(SAMPLES),
        "calibration count reached run length")
    `JCCM_ASSERT_NEXT(a_run_clear,
        advance && in_word_reg.action == ACT_CAL && run_end,
        sum_x_reg == '0 && sum_y_reg == '0 && count_reg == '0
        && result_word_reg.calibration_done,
        "accumulators not cleared at end of run")
    `JCCM_ASSERT_NOW(a_stall_full, sample_stall, in_valid_reg && result_valid_reg,
        "sample side stalled with a free register")

endmodule
